// ===== rtl/hwt_pkg.sv =====
// ---------------------------------------------------------------------------
// Haar wavelet transform engine - shared definitions
// Value widths, the 1/sqrt2 scale constant and the request/response
// bundles between the sequencer and the shared scaling unit.
// ---------------------------------------------------------------------------
package hwt_pkg;

  // Q20.16 sample width and the width of a butterfly sum or difference
  localparam int VAL_W = 36;
  localparam int SUM_W = VAL_W + 1;

  // magnitude split for the two partial products
  localparam int LO_W   = 16;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int K_W    = 32;
  localparam int PROD_W = HI_W + K_W;
  localparam int PLO_W  = LO_W + K_W;
  localparam int T_W    = PLO_W + 1;
  localparam int R_W    = SUM_W + 1;

  // default frame capacity
  localparam int MAX_SAMPLES_DEF = 64;

  // 1/sqrt(2) in Q0.32
  localparam logic [K_W-1:0] INV_SQRT2_Q32 = 32'd3037000500;

  // saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = 36'h7_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 36'h8_0000_0000;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // sequencer -> scaling unit
  typedef struct packed {
    logic start;
    sum_t operand;
  } scale_req_t;

  // scaling unit -> sequencer
  typedef struct packed {
    logic done;
    val_t result;
  } scale_rsp_t;

endpackage

// ===== rtl/hwt_ram.sv =====
// ---------------------------------------------------------------------------
// Haar wavelet transform engine - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module hwt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hwt_scale.sv =====
// ---------------------------------------------------------------------------
// Haar wavelet transform engine - shared scaling unit
// Multiplies a butterfly sum or difference by 1/sqrt2, rounds to nearest
// (ties away from zero) and saturates to Q20.16. One shared multiplier
// forms the low partial product first, then the high one.
// ---------------------------------------------------------------------------
module hwt_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  hwt_pkg::scale_req_t req,
  output hwt_pkg::scale_rsp_t rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_SAT
  } step_t;

  step_t                          state_r;
  logic                           done_r;
  logic                           neg_r;
  logic [hwt_pkg::HI_W-1:0]       hi_r;
  logic [hwt_pkg::LO_W-1:0]       lo_r;
  logic [hwt_pkg::PLO_W-1:0]      p_lo_r;
  logic [hwt_pkg::PROD_W-1:0]     p_hi_r;
  logic [hwt_pkg::T_W-1:0]        t_r;
  logic [hwt_pkg::VAL_W-1:0]      res_r;

  logic [hwt_pkg::SUM_W-1:0]      mag;
  logic [hwt_pkg::HI_W-1:0]       mul_a;
  logic [hwt_pkg::PROD_W-1:0]     mul_p;
  logic [hwt_pkg::T_W-1:0]        t_nxt;
  logic [hwt_pkg::R_W-1:0]        r_sum;
  logic [hwt_pkg::VAL_W-1:0]      sat_nxt;

  // magnitude of the incoming operand
  assign mag = req.operand[hwt_pkg::SUM_W-1]
             ? (hwt_pkg::SUM_W'(0) - hwt_pkg::SUM_W'(req.operand))
             : hwt_pkg::SUM_W'(req.operand);

  // shared multiplier: low half first, then high half
  assign mul_a = (state_r == ST_MUL_LO) ? hwt_pkg::HI_W'(lo_r) : hi_r;
  assign mul_p = hwt_pkg::PROD_W'(mul_a) * hwt_pkg::PROD_W'(hwt_pkg::INV_SQRT2_Q32);

  // rounding sum of the low terms
  assign t_nxt = hwt_pkg::T_W'({p_hi_r[15:0], 16'h0000})
               + hwt_pkg::T_W'(p_lo_r)
               + hwt_pkg::T_W'(33'h0_8000_0000);

  // final magnitude, then sign and saturation
  assign r_sum = hwt_pkg::R_W'(p_hi_r[hwt_pkg::PROD_W-1:16])
               + hwt_pkg::R_W'(t_r[hwt_pkg::T_W-1:32]);

  always_comb begin
    if (neg_r) begin
      if (r_sum > hwt_pkg::R_W'(36'h8_0000_0000)) begin
        sat_nxt = hwt_pkg::VAL_MIN;
      end else begin
        sat_nxt = hwt_pkg::VAL_W'(hwt_pkg::R_W'(0) - r_sum);
      end
    end else begin
      if (r_sum > hwt_pkg::R_W'(hwt_pkg::VAL_MAX)) begin
        sat_nxt = hwt_pkg::VAL_MAX;
      end else begin
        sat_nxt = r_sum[hwt_pkg::VAL_W-1:0];
      end
    end
  end

  // step sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      // done pulses for one cycle after the saturation step
      done_r <= (state_r == ST_SAT);
      unique case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            neg_r   <= req.operand[hwt_pkg::SUM_W-1];
            hi_r    <= mag[hwt_pkg::SUM_W-1:hwt_pkg::LO_W];
            lo_r    <= mag[hwt_pkg::LO_W-1:0];
            state_r <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          p_lo_r  <= mul_p[hwt_pkg::PLO_W-1:0];
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          p_hi_r  <= mul_p;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          t_r     <= t_nxt;
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          res_r   <= sat_nxt;
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  // a new operand only arrives while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == ST_IDLE)
    else $error("scale unit started while busy");

  // completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("scale done held for more than one cycle");

  // completion follows the saturation step
  a_done_after_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SAT |=> done_r)
    else $error("scale done missing after saturation step");

endmodule

// ===== rtl/haar_wavelet_transform_engine.sv =====
// ---------------------------------------------------------------------------
// Haar wavelet transform engine - top level
// Collects a frame of Q20.16 samples, zero-pads it to a power of two and
// runs the full orthonormal Haar decomposition or reconstruction on one
// shared scaling unit, then streams the first n values back out.
//
// Usage:
//  - Input beats (in_sample, in_last_sample) load one per cycle while in_stall
//    is low; the beat with in_last_sample set closes the frame. Samples past
//    MAX_SAMPLES are dropped, but a last flag on them still closes the frame.
//  - cfg_wr_en/cfg_wr_data set the direction (0 forward, 1 inverse); the
//    value held when the last beat arrives is used.
//  - in_stall is high from the last beat until the final result has been
//    loaded into the output register.
//  - After the last beat the sequencer zero-pads the frame to P, the padded
//    size, then runs P - 1 butterflies (two memory reads, then two passes
//    through the scaling unit) and 2P - 2 copy-backs, and then emits the
//    output beats. Each output beat waits on its own frame store read, so
//    output beats are never loaded back to back.
//  - out_stall holds the output register; the sequencer waits on it.
//  - Reset (rst_n low, synchronous) empties the frame, clears the output
//    valid and sets the direction to forward. No memory clearing pass.
// ---------------------------------------------------------------------------
module haar_wavelet_transform_engine #(
  parameter int MAX_SAMPLES = hwt_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [35:0]        in_sample,
  input  logic                      in_last_sample,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [35:0]        out_value,
  output logic                      out_last_value,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_wr_data
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int LW    = AW + 1;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PREP,
    S_PAD,
    S_RD_A,
    S_RD_B,
    S_GET_B,
    S_SUM,
    S_WAIT_SUM,
    S_WAIT_DIFF,
    S_COPY_RD,
    S_COPY_WR,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t              state_r;
  logic [LW-1:0]       count_r;
  logic [LW-1:0]       n_r;
  logic [LW-1:0]       padded_r;
  logic [LW-1:0]       len_r;
  logic [LW-1:0]       idx_r;
  logic                dir_r;
  logic                cfg_dir_r;
  hwt_pkg::val_t       a_r;
  hwt_pkg::val_t       b_r;
  logic                out_valid_r;
  hwt_pkg::val_t       out_value_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_free;
  logic                count_lt_max;
  logic [LW-1:0]       n_nxt;
  logic [LW-1:0]       half;
  logic [LW-1:0]       a_idx;
  logic [LW-1:0]       b_idx;
  logic [LW-1:0]       sum_idx;
  logic [LW-1:0]       diff_idx;

  logic                fr_we;
  logic [AW-1:0]       fr_waddr;
  hwt_pkg::val_t       fr_wdata;
  logic [AW-1:0]       fr_raddr;
  hwt_pkg::val_t       fr_rdata;
  logic                sc_we;
  logic [AW-1:0]       sc_waddr;
  hwt_pkg::val_t       sc_wdata;
  logic [AW-1:0]       sc_raddr;
  hwt_pkg::val_t       sc_rdata;

  hwt_pkg::scale_req_t sreq;
  hwt_pkg::scale_rsp_t srsp;

  // smallest power of two not below n (n >= 1)
  function automatic logic [LW-1:0] ceil_pow2(input logic [LW-1:0] n);
    logic [LW-1:0] p;
    p = LW'(1);
    for (int k = 0; k < LW; k++) begin
      if (p < n) begin
        p = p << 1;
      end
    end
    return p;
  endfunction

  // handshake
  assign in_stall     = (state_r != S_LOAD);
  assign in_acc       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign count_lt_max = (count_r < LW'(MAX_SAMPLES));
  assign n_nxt        = count_lt_max ? (count_r + LW'(1)) : count_r;

  // butterfly addressing: forward reads pairs, writes halves; inverse opposite
  assign half     = len_r >> 1;
  assign a_idx    = dir_r ? idx_r : (idx_r << 1);
  assign b_idx    = dir_r ? (half + idx_r) : ((idx_r << 1) | LW'(1));
  assign sum_idx  = dir_r ? (idx_r << 1) : idx_r;
  assign diff_idx = dir_r ? ((idx_r << 1) | LW'(1)) : (half + idx_r);

  // frame store ports
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = idx_r[AW-1:0];
    fr_wdata = sc_rdata;
    fr_raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        fr_we    = in_acc && count_lt_max;
        fr_waddr = count_r[AW-1:0];
        fr_wdata = in_sample;
      end
      S_PAD: begin
        fr_we    = (idx_r != padded_r);
        fr_wdata = '0;
      end
      S_COPY_WR: begin
        fr_we = 1'b1;
      end
      S_RD_A: begin
        fr_raddr = a_idx[AW-1:0];
      end
      S_RD_B: begin
        fr_raddr = b_idx[AW-1:0];
      end
      default: begin
        fr_we = 1'b0;
      end
    endcase
  end

  // scratch store ports
  assign sc_we    = ((state_r == S_WAIT_SUM) || (state_r == S_WAIT_DIFF)) && srsp.done;
  assign sc_waddr = (state_r == S_WAIT_SUM) ? sum_idx[AW-1:0] : diff_idx[AW-1:0];
  assign sc_wdata = srsp.result;
  assign sc_raddr = idx_r[AW-1:0];

  // scaling unit requests: sum first, difference as soon as the sum lands
  assign sreq.start   = (state_r == S_SUM) || ((state_r == S_WAIT_SUM) && srsp.done);
  assign sreq.operand = (state_r == S_SUM)
                      ? (hwt_pkg::SUM_W'(a_r) + hwt_pkg::SUM_W'(b_r))
                      : (hwt_pkg::SUM_W'(a_r) - hwt_pkg::SUM_W'(b_r));

  hwt_ram #(
    .WIDTH (hwt_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (fr_we),
    .wr_addr (fr_waddr),
    .wr_data (fr_wdata),
    .rd_addr (fr_raddr),
    .rd_data (fr_rdata)
  );

  hwt_ram #(
    .WIDTH (hwt_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_scratch_ram (
    .clk     (clk),
    .wr_en   (sc_we),
    .wr_addr (sc_waddr),
    .wr_data (sc_wdata),
    .rd_addr (sc_raddr),
    .rd_data (sc_rdata)
  );

  hwt_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      cfg_dir_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_dir_r <= cfg_wr_data[0];
      end
      // result taken and no new one loaded this cycle
      if (out_valid_r && !out_stall && (state_r != S_EMIT_LD)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_last_sample) begin
              n_r     <= n_nxt;
              dir_r   <= cfg_dir_r;
              count_r <= '0;
              state_r <= S_PREP;
            end else if (count_lt_max) begin
              count_r <= count_r + LW'(1);
            end
          end
        end
        S_PREP: begin
          padded_r <= ceil_pow2(n_r);
          idx_r    <= n_r;
          state_r  <= S_PAD;
        end
        S_PAD: begin
          if (idx_r == padded_r) begin
            idx_r <= '0;
            len_r <= dir_r ? LW'(2) : padded_r;
            if (padded_r == LW'(1)) begin
              state_r <= S_EMIT_RD;
            end else begin
              state_r <= S_RD_A;
            end
          end else begin
            idx_r <= idx_r + LW'(1);
          end
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          a_r     <= fr_rdata;
          state_r <= S_GET_B;
        end
        S_GET_B: begin
          b_r     <= fr_rdata;
          state_r <= S_SUM;
        end
        S_SUM: begin
          state_r <= S_WAIT_SUM;
        end
        S_WAIT_SUM: begin
          if (srsp.done) begin
            state_r <= S_WAIT_DIFF;
          end
        end
        S_WAIT_DIFF: begin
          if (srsp.done) begin
            if (idx_r == half - LW'(1)) begin
              idx_r   <= '0;
              state_r <= S_COPY_RD;
            end else begin
              idx_r   <= idx_r + LW'(1);
              state_r <= S_RD_A;
            end
          end
        end
        S_COPY_RD: begin
          state_r <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (idx_r == len_r - LW'(1)) begin
            // level finished
            idx_r <= '0;
            if (dir_r) begin
              if (len_r == padded_r) begin
                state_r <= S_EMIT_RD;
              end else begin
                len_r   <= len_r << 1;
                state_r <= S_RD_A;
              end
            end else begin
              if (len_r == LW'(2)) begin
                state_r <= S_EMIT_RD;
              end else begin
                len_r   <= len_r >> 1;
                state_r <= S_RD_A;
              end
            end
          end else begin
            idx_r   <= idx_r + LW'(1);
            state_r <= S_COPY_RD;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= fr_rdata;
            out_last_r  <= (idx_r == n_r - LW'(1));
            if (idx_r == n_r - LW'(1)) begin
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + LW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_last_value = out_last_r;

  // closing beat always starts the transform
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_sample |=> state_r == S_PREP)
    else $error("frame close did not start the transform");

  // fill count never passes the frame capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(MAX_SAMPLES))
    else $error("frame count beyond capacity");

  // level length stays within the padded frame while levels run
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_A || state_r == S_COPY_WR) |-> len_r <= padded_r && len_r >= LW'(2))
    else $error("level length out of range");

  // an output register held by the receiver is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_value_r) && $stable(out_last_r))
    else $error("stalled result overwritten");

endmodule
